// ===== hdl/cbts_pkg.sv =====
package cbts_pkg;

  localparam int BR_W   = 24;
  localparam int MUL_W  = 8;
  localparam int Q_W    = 5;
  localparam int CLK_W  = 32;
  localparam int SEG1_W = 5;
  localparam int SEG2_W = 3;
  localparam int PROD_W = CLK_W + MUL_W;

  localparam int BASE_QUANTA_DEF = 16;
  localparam int MAX_OFFSET_DEF  = 9;

  localparam logic [CLK_W-1:0] CLK_RESET = 32'd16000000;

  typedef struct packed {
    logic [BR_W-1:0]  bitrate;
    logic [MUL_W-1:0] multiplier;
  } req_t;

  typedef struct packed {
    logic              timing_error;
    logic [Q_W-1:0]    time_quanta;
    logic [CLK_W-1:0]  prescaler;
    logic              jump_width;
    logic [SEG1_W-1:0] segment_one;
    logic [SEG2_W-1:0] segment_two;
  } res_t;

endpackage

// ===== hdl/cbts_ser_mul.sv =====
module cbts_ser_mul #(
  parameter int AW = cbts_pkg::CLK_W,
  parameter int BW = cbts_pkg::MUL_W
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [BW-1:0]   b,
  output logic            done,
  output logic [AW+BW-1:0] product
);
  import cbts_pkg::*;

  logic [AW+BW-1:0] a_sh;
  logic [AW+BW-1:0] acc;
  logic [BW-1:0]    b_sh;
  logic             running;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sh    <= (AW+BW)'(a);
        b_sh    <= b;
        acc     <= '0;
        running <= 1'b1;
      end else if (running) begin
        // stop as soon as no multiplier bits remain
        if (b_sh == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          if (b_sh[0]) begin
            acc <= acc + a_sh;
          end
          a_sh <= a_sh << 1;
          b_sh <= b_sh >> 1;
        end
      end
    end
  end

  assign product = acc;

endmodule

// ===== hdl/cbts_ser_div.sv =====
module cbts_ser_div #(
  parameter int NW = cbts_pkg::CLK_W,
  parameter int DW = cbts_pkg::PROD_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);
  import cbts_pkg::*;

  localparam int CW = $clog2(NW);

  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          running;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo     <= dividend;
        rem     <= '0;
        dvs     <= divisor;
        cnt     <= CW'(NW - 1);
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/can_bit_timing_solver_core.sv =====
// CAN bit timing solver. Pulse start with a request while busy is low; busy
// stays high until the result appears. The result is shown for exactly one
// cycle with done high and cannot be held off, so the receiver must take it
// then. An item first forms bitrate times multiplier on the bit-serial
// multiplier, then tries quanta counts, up to 2*(MAX_OFFSET+1) of them, each
// with a multiply and a divide, and ends with a multiply and the prescaler
// divide. Every divide runs on the shared restoring divider, which produces
// one quotient bit per cycle. A zero bitrate or multiplier is answered with
// an error in the cycle right after the item is taken.
// The clock frequency register is written through cfg_valid/cfg_ready/cfg_data
// while the block is idle.
module can_bit_timing_solver_core #(
  parameter int BASE_QUANTA = cbts_pkg::BASE_QUANTA_DEF,
  parameter int MAX_OFFSET  = cbts_pkg::MAX_OFFSET_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  cbts_pkg::req_t             request,
  output logic                       done,
  output cbts_pkg::res_t             result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cbts_pkg::CLK_W-1:0] cfg_data
);
  import cbts_pkg::*;

  localparam int K_W = $clog2(MAX_OFFSET + 1);

  // error flag set, every other field zero
  localparam res_t ERR_RESULT = res_t'({1'b1, {($bits(res_t) - 1){1'b0}}});

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_BM     = 7'b0000010,
    S_LAUNCH = 7'b0000100,
    S_TQ     = 7'b0001000,
    S_TDIV   = 7'b0010000,
    S_PQ     = 7'b0100000,
    S_PDIV   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [SEG1_W-1:0] seg1;
    logic [SEG2_W-1:0] seg2;
  } seg_t;

  function automatic seg_t seg_calc(input logic [Q_W-1:0] q);
    logic signed [10:0] q7;
    logic signed [10:0] base;
    logic signed [10:0] s1;
    logic signed [10:0] d0;
    logic signed [10:0] d1;
    logic signed [10:0] s2;
    seg_t               r;
    q7   = $signed(11'(q)) * 11'sd7;
    base = q7 >>> 3;
    if (base < 11'sd1) begin
      base = 11'sd1;
    end
    s1 = base - 11'sd1;
    d0 = ((s1 + 11'sd1) <<< 3) - q7;
    d1 = ((s1 + 11'sd2) <<< 3) - q7;
    if (d0 < 0) begin
      d0 = -d0;
    end
    if (d1 < 0) begin
      d1 = -d1;
    end
    // move the sample point one quantum later only if strictly closer to 7/8
    if (d1 < d0) begin
      s1 = s1 + 11'sd1;
    end
    s2 = $signed(11'(q)) - s1 - 11'sd1;
    if (s2 < 0) begin
      s2 = '0;
    end
    r.seg1 = s1[SEG1_W-1:0];
    r.seg2 = s2[SEG2_W-1:0];
    return r;
  endfunction

  state_t            state;
  logic [CLK_W-1:0]  clock_freq;
  logic [BR_W-1:0]   rate;
  logic [CLK_W-1:0]  bm;
  logic [K_W-1:0]    k;
  logic              side;

  logic [Q_W-1:0]    lo_q;
  logic [Q_W-1:0]    hi_q;
  logic              lo_ok;
  logic [Q_W-1:0]    q_cand;
  logic              last_trial;
  logic              bad_req;
  seg_t              seg;

  logic              mul_start;
  logic [CLK_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_p;

  logic              div_start;
  logic              div_done;
  logic [CLK_W-1:0]  div_quo;
  logic [PROD_W-1:0] div_rem;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = ~busy;

  // candidate count: BASE-k first (BASE+k once k reaches BASE), then BASE+k
  assign lo_q       = Q_W'(BASE_QUANTA) - Q_W'(k);
  assign hi_q       = Q_W'(BASE_QUANTA) + Q_W'(k);
  assign lo_ok      = (int'(k) < BASE_QUANTA);
  assign q_cand     = (!side && lo_ok) ? lo_q : hi_q;
  assign last_trial = side && (k == K_W'(MAX_OFFSET));
  assign bad_req    = (request.bitrate == '0) || (request.multiplier == '0);
  assign seg        = seg_calc(q_cand);

  always_comb begin
    case (state)
      S_IDLE: begin
        mul_a = CLK_W'(request.bitrate);
        mul_b = request.multiplier;
      end
      S_LAUNCH: begin
        mul_a = bm;
        mul_b = MUL_W'(q_cand);
      end
      default: begin
        mul_a = CLK_W'(rate);
        mul_b = MUL_W'(q_cand);
      end
    endcase
  end

  assign mul_start = (state == S_IDLE && start && !bad_req) ||
                     (state == S_LAUNCH) ||
                     (state == S_TDIV && div_done && div_rem == '0);
  assign div_start = (state == S_TQ || state == S_PQ) && mul_done;

  cbts_ser_mul #(
    .AW(CLK_W),
    .BW(MUL_W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .product(mul_p)
  );

  cbts_ser_div #(
    .NW(CLK_W),
    .DW(PROD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_freq),
    .divisor  (mul_p),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      clock_freq <= CLK_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        clock_freq <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            rate <= request.bitrate;
            k    <= '0;
            side <= 1'b0;
            if (bad_req) begin
              result <= ERR_RESULT;
              done   <= 1'b1;
            end else begin
              state <= S_BM;
            end
          end
        end
        S_BM: begin
          if (mul_done) begin
            bm    <= mul_p[CLK_W-1:0];
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_TQ;
        end
        S_TQ: begin
          if (mul_done) begin
            state <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              state <= S_PQ;
            end else if (last_trial) begin
              result <= ERR_RESULT;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              // advance to the next candidate count
              if (side) begin
                k    <= k + 1'b1;
                side <= 1'b0;
              end else begin
                side <= 1'b1;
              end
              state <= S_LAUNCH;
            end
          end
        end
        S_PQ: begin
          if (mul_done) begin
            state <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            result.timing_error <= 1'b0;
            result.time_quanta  <= q_cand;
            result.prescaler    <= div_quo;
            result.jump_width   <= 1'b1;
            result.segment_one  <= seg.seg1;
            result.segment_two  <= seg.seg2;
            done                <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.timing_error |->
      result.time_quanta == '0 && result.prescaler == '0 && !result.jump_width &&
      result.segment_one == '0 && result.segment_two == '0)
    else $error("error result carries nonzero fields");

  a_seg_sum: assert property (@(posedge clk) disable iff (rst)
    done && !result.timing_error |->
      7'(result.segment_one) + 7'(result.segment_two) + 7'd1 == 7'(result.time_quanta) &&
      result.jump_width)
    else $error("segments do not add up to the quanta count");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy || $past(state == S_IDLE))
    else $error("result strobe while still solving");

endmodule
